FILE: design/wpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wpm_pkg;

    localparam int SOURCE_SLOTS_DEF = 8;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_SAMPLE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_ACC,
        S_RESP
    } state_t;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_MIX    = 1'b1;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_REJECT   = 1'b1;

    localparam logic signed [15:0] MIX_MAX = 16'sh7FFF;
    localparam logic signed [15:0] MIX_MIN = -16'sh8000;
    // clip bounds of the sum with 12 fraction bits
    localparam logic signed [32:0] TOT_MAX = 33'sd134213632;
    localparam logic signed [32:0] TOT_MIN = -33'sd134217728;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] wt;
        logic        mute;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic accum;
        logic push;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic is_sample;
        logic has_result;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/wpm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wpm_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire wpm_pkg::dp_stat_t stat,
    output wpm_pkg::dp_cmd_t      cmd
);
    import wpm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.is_sample ? S_ACC : S_RESP;
            end
            S_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                // a sample without the last mark has nothing to send
                if (!stat.has_result)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/wpm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module wpm_datapath #(
    parameter int SOURCE_SLOTS = wpm_pkg::SOURCE_SLOTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wpm_pkg::dp_cmd_t   cmd,
    output wpm_pkg::dp_stat_t       stat,
    input  wire logic [1:0]         op,
    input  wire logic [31:0]        source_id,
    input  wire logic signed [15:0] weight,
    input  wire logic               muted,
    input  wire logic signed [15:0] sample,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    result_kind,
    output logic                    status,
    output logic [3:0]              source_total,
    output logic signed [15:0]      mixed_sample
);
    import wpm_pkg::*;

    localparam int IW  = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
    localparam int OW  = $clog2(SOURCE_SLOTS + 1);
    localparam int OWX = (OW > 4) ? OW : 4;
    localparam logic [IW-1:0] LAST_IDX = IW'(SOURCE_SLOTS - 1);
    localparam logic [OW-1:0] FULL_CNT = OW'(SOURCE_SLOTS);

    // request being worked on
    op_t                op_reg;
    logic [31:0]        id_reg;
    logic [15:0]        wt_reg;
    logic               mute_reg;
    logic signed [15:0] sample_reg;
    logic               last_reg;

    // slot table
    entry_t                  mem [SOURCE_SLOTS];
    entry_t                  rd_entry_reg;
    logic [SOURCE_SLOTS-1:0] valid_reg;
    logic [OW-1:0]           occ_reg;

    // search
    logic               scan_run_reg;
    logic [IW-1:0]      scan_idx_reg;
    logic               cmp_vld_reg;
    logic [IW-1:0]      cmp_idx_reg;
    logic               found_reg;
    logic [IW-1:0]      hit_idx_reg;
    logic signed [15:0] hit_wt_reg;
    logic               hit_mute_reg;
    logic               free_found_reg;
    logic [IW-1:0]      free_idx_reg;

    // mixing
    logic signed [31:0] product_reg;
    logic signed [15:0] sum_reg;
    logic               res_kind_reg;
    logic               res_status_reg;
    logic signed [15:0] res_mixed_reg;

    // output stage
    logic               out_valid_reg;
    logic               out_kind_reg;
    logic               out_status_reg;
    logic [3:0]         out_total_reg;
    logic signed [15:0] out_mixed_reg;

    logic               full;
    logic               add_ok;
    logic               op_ok;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    entry_t             wr_entry;
    logic signed [31:0] prod_full;
    logic signed [32:0] acc_total;
    logic               frac_nz;
    logic signed [15:0] trunc_q;
    logic signed [15:0] new_sum;
    logic [OWX-1:0]     occ_ext;

    assign full   = (occ_reg == FULL_CNT);
    assign add_ok = !full && !found_reg && free_found_reg;

    always_comb
    begin
        unique case (op_reg)
            OP_ADD:    op_ok = add_ok;
            OP_REMOVE: op_ok = found_reg;
            OP_UPDATE: op_ok = found_reg;
            OP_SAMPLE: op_ok = 1'b1;
            default:   op_ok = 1'b0;
        endcase
    end

    assign wr_en    = cmd.exec && (((op_reg == OP_ADD) && add_ok)
                                   || ((op_reg == OP_UPDATE) && found_reg));
    assign wr_addr  = (op_reg == OP_ADD) ? free_idx_reg : hit_idx_reg;
    assign wr_entry = '{id: id_reg, wt: wt_reg, mute: mute_reg};

    assign prod_full = sample_reg * hit_wt_reg;

    // sum with 12 fraction bits plus the new product
    assign acc_total = $signed({{5{sum_reg[15]}}, sum_reg, 12'b0})
                     + $signed({product_reg[31], product_reg});
    assign frac_nz   = |acc_total[11:0];
    // floor, then one up for negative values with a fraction: toward zero
    assign trunc_q   = acc_total[27:12] + 16'(acc_total[32] && frac_nz);

    always_comb
    begin
        priority if (acc_total > TOT_MAX)
        begin
            new_sum = MIX_MAX;
        end
        else if (acc_total < TOT_MIN)
        begin
            new_sum = MIX_MIN;
        end
        else
        begin
            new_sum = trunc_q;
        end
    end

    assign occ_ext = OWX'(occ_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op_t'(op);
            id_reg     <= source_id;
            wt_reg     <= weight;
            mute_reg   <= muted;
            sample_reg <= sample;
            last_reg   <= last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[scan_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_run_reg   <= 1'b0;
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                scan_run_reg   <= 1'b1;
                scan_idx_reg   <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (scan_run_reg)
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    scan_run_reg <= 1'b0;
                end
                else
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
            end
            cmp_vld_reg <= scan_run_reg && !cmd.capture;
            cmp_idx_reg <= scan_idx_reg;
            if (cmp_vld_reg)
            begin
                if (valid_reg[cmp_idx_reg] && (rd_entry_reg.id == id_reg) && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
                if (!valid_reg[cmp_idx_reg] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmp_vld_reg)
        begin
            if (valid_reg[cmp_idx_reg] && (rd_entry_reg.id == id_reg) && !found_reg)
            begin
                hit_idx_reg  <= cmp_idx_reg;
                hit_wt_reg   <= $signed(rd_entry_reg.wt);
                hit_mute_reg <= rd_entry_reg.mute;
            end
            if (!valid_reg[cmp_idx_reg] && !free_found_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            if (cmd.exec && (op_reg == OP_ADD) && add_ok)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                occ_reg                 <= occ_reg + 1'b1;
            end
            else if (cmd.exec && (op_reg == OP_REMOVE) && found_reg)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
                occ_reg                <= occ_reg - 1'b1;
            end
            if (cmd.accum)
            begin
                sum_reg <= last_reg ? 16'sd0 : new_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            // unknown or muted source contributes zero
            product_reg    <= (found_reg && !hit_mute_reg) ? prod_full : 32'sd0;
            res_kind_reg   <= KIND_STATUS;
            res_status_reg <= op_ok ? ST_OK : ST_REJECT;
            res_mixed_reg  <= 16'sd0;
        end
        else if (cmd.accum)
        begin
            res_kind_reg   <= KIND_MIX;
            res_status_reg <= ST_OK;
            res_mixed_reg  <= new_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_kind_reg   <= res_kind_reg;
            out_status_reg <= res_status_reg;
            out_total_reg  <= occ_ext[3:0];
            out_mixed_reg  <= res_mixed_reg;
        end
    end

    assign stat.scan_done  = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);
    assign stat.is_sample  = (op_reg == OP_SAMPLE);
    assign stat.has_result = (op_reg != OP_SAMPLE) || last_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign status       = out_status_reg;
    assign source_total = out_total_reg;
    assign mixed_sample = out_mixed_reg;

`ifndef SYNTHESIS
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == OW'($countones(valid_reg)))
        else $error("occupancy count out of step with slot valid bits");

    a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid_reg || out_ready))
        else $error("result pushed over an untaken result");

    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accum && last_reg) |=> (sum_reg == 16'sd0))
        else $error("mix sum not cleared after frame end");

    a_no_scan_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec || cmd.accum) |-> !scan_run_reg)
        else $error("table update while search still running");
`endif

endmodule

`default_nettype wire

FILE: design/weighted_pcm_mixer_top.sv
// Weighted PCM mixer. Keeps a table of up to SOURCE_SLOTS sources (32-bit id,
// signed Q3.12 weight, mute flag). op 0/1/2 add, remove or update a source and
// always return one status result (status 1 = rejected: table full, duplicate
// id, or unknown id). op 3 supplies one sample of one source; a known unmuted
// source adds sample*weight to the frame sum, which is clipped to 16 bits and
// truncated toward zero after every addition. A sample with last set returns
// the mix and clears the sum; other samples return nothing. Every request
// searches the slot memory one slot per cycle; a sample request then also
// passes an accumulate state that a table request skips. A finished result sits
// in an output register, so the next request is accepted while the result waits.
`timescale 1ns / 1ps
`default_nettype none

module weighted_pcm_mixer_top #(
    parameter int SOURCE_SLOTS = wpm_pkg::SOURCE_SLOTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         op,
    input  wire logic [31:0]        source_id,
    input  wire logic signed [15:0] weight,
    input  wire logic               muted,
    input  wire logic signed [15:0] sample,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    result_kind,
    output logic                    status,
    output logic [3:0]              source_total,
    output logic signed [15:0]      mixed_sample
);
    import wpm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    wpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wpm_datapath #(
        .SOURCE_SLOTS (SOURCE_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .source_id    (source_id),
        .weight       (weight),
        .muted        (muted),
        .sample       (sample),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .status       (status),
        .source_total (source_total),
        .mixed_sample (mixed_sample)
    );

endmodule

`default_nettype wire
